// ===== hdl/cubic_spline_evaluator_unit_defines.svh =====
// Assertion macros shared by the checker files of the spline evaluator.
`ifndef CUBIC_SPLINE_EVALUATOR_UNIT_DEFINES_SVH
`define CUBIC_SPLINE_EVALUATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cse_pkg.sv =====
// Types and constants of the cubic spline evaluator.
package cse_pkg;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_CHK0 = 10'b00_0000_0010,
    ST_CHKN = 10'b00_0000_0100,
    ST_SRCH = 10'b00_0000_1000,
    ST_CMP  = 10'b00_0001_0000,
    ST_LO   = 10'b00_0010_0000,
    ST_HI   = 10'b00_0100_0000,
    ST_DIV  = 10'b00_1000_0000,
    ST_MUL  = 10'b01_0000_0000,
    ST_SAT  = 10'b10_0000_0000
  } state_t;

  // Operations of the shared multiplier
  typedef enum logic [4:0] {
    MOP_A2  = 5'd0,
    MOP_A3  = 5'd1,
    MOP_B2  = 5'd2,
    MOP_B3  = 5'd3,
    MOP_MA  = 5'd4,
    MOP_MB  = 5'd5,
    MOP_MA2 = 5'd6,
    MOP_MB2 = 5'd7,
    MOP_DAH = 5'd8,
    MOP_DAL = 5'd9,
    MOP_DBH = 5'd10,
    MOP_DBL = 5'd11,
    MOP_VA  = 5'd12,
    MOP_VB  = 5'd13,
    MOP_CAL = 5'd14,
    MOP_CAH = 5'd15,
    MOP_CBL = 5'd16,
    MOP_CBH = 5'd17
  } mop_t;

  // Request kinds on in_action
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam int unsigned DIV_STEPS  = 31;  // quotient bits of A
  // ceil(2^30 / 6): exact divide by six for operands below 2^29
  localparam logic [31:0] RECIP6_Q30 = 32'd178956971;
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

endpackage

// ===== hdl/cubic_spline_evaluator_unit.sv =====
// Cubic spline evaluator: knot table memory, segment search and fixed-point datapath.
//
//  channel | direction | request carries
//  --------+-----------+---------------------------------------------------------
//  cfg_    | in        | knot_count write (no handshake, no read-back)
//  in_     | in        | load knot (index, pos, value, curvature) or evaluate query
//  out_    | out       | spline_value for each evaluate, Q16.16 saturated
//
// Load requests are written while the block stays idle. In an in-range evaluate, the end
// checks and the binary search share the single read port of the knot memory (a search
// and a compare state per probe), A comes from a one-bit-per-cycle divider, eighteen
// products share one 32x32 multiplier (a multiply and a write-back phase each), the
// divide by six included as two reciprocal multiplies per factor. Queries outside the
// knot range and zero-width segments go straight to saturation.
// Reset (rst_n low, synchronous) empties the pipeline and sets knot_count to 2; the
// knot memory is not cleared. A result waits in the output register under out_stall
// and the next request is taken meanwhile; a later result waits behind it.
module cubic_spline_evaluator_unit #(
  parameter int MAX_KNOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [6:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [5:0]         in_knot_index,
  input  logic signed [31:0] in_knot_pos,
  input  logic signed [31:0] in_knot_value,
  input  logic signed [31:0] in_knot_curvature,
  input  logic signed [31:0] in_query_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_spline_value
);

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;  // memory address
  localparam int NW = $clog2(MAX_KNOTS + 1);                    // knot counts

  // Knot memory: {pos, value, curvature} per entry, registered read.
  // Loads happen only in idle; an evaluate's reads start in the cycle it is taken, which
  // holds no load, so the two never touch the same entry in overlapping cycles.
  logic [95:0]   knot_mem [MAX_KNOTS];
  logic [95:0]   rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  assign mem_we = in_valid && !in_stall && (in_action == cse_pkg::ACT_LOAD) &&
                  (32'(in_knot_index) < 32'(MAX_KNOTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      knot_mem[AW'(in_knot_index)] <= {in_knot_pos, in_knot_value, in_knot_curvature};
    end
    rd_q <= knot_mem[rd_addr];
  end

  logic signed [31:0] rd_pos, rd_val, rd_curv;
  assign rd_pos  = rd_q[95:64];
  assign rd_val  = rd_q[63:32];
  assign rd_curv = rd_q[31:0];

  // Registers
  cse_pkg::state_t    state_r, state_nxt;
  cse_pkg::mop_t      mop_r, mop_nxt;
  logic               phase_r, phase_nxt;
  logic [6:0]         knot_count_r, knot_count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic [NW-1:0]      first_r, first_nxt;
  logic [NW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic signed [31:0] v0_r, v0_nxt, c0_r, c0_nxt, v1_r, v1_nxt, c1_r, c1_nxt;
  logic signed [31:0] lo_pos_r, lo_pos_nxt;
  logic [31:0]        dx_r, dx_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [30:0]        a_r, a_nxt;
  logic [30:0]        a2_r, a2_nxt, b2_r, b2_nxt;
  logic [30:0]        ta_r, ta_nxt, tb_r, tb_nxt;
  logic [31:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic [47:0]        qa_r, qa_nxt, qb_r, qb_nxt;
  logic [2:0]         ra_r, ra_nxt, rb_r, rb_nxt;
  logic [47:0]        lo_r, lo_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic signed [63:0] acc_r, acc_nxt;

  // Clamped knot count
  logic [NW-1:0] n_cl;
  always_comb begin
    priority if (knot_count_r < 7'd2) n_cl = NW'(2);
    else if (32'(knot_count_r) > 32'(MAX_KNOTS)) n_cl = NW'(MAX_KNOTS);
    else n_cl = NW'(knot_count_r);
  end

  // Search helpers
  logic [NW-1:0] step_w, jt;
  logic [AW-1:0] mid_w, j_sel;
  assign step_w = count_r >> 1;
  assign mid_w  = AW'(first_r + step_w);
  always_comb begin
    jt = (first_r == '0) ? '0 : first_r - NW'(1);
    if (jt > n_cl - NW'(2)) jt = n_cl - NW'(2);
    j_sel = AW'(jt);
  end

  always_comb begin
    unique case (state_r)
      cse_pkg::ST_IDLE: rd_addr = '0;
      cse_pkg::ST_CHK0: rd_addr = AW'(n_cl - NW'(1));
      cse_pkg::ST_SRCH: rd_addr = (count_r == '0) ? j_sel : mid_w;
      cse_pkg::ST_LO:   rd_addr = j_r + AW'(1);
      default:          rd_addr = '0;
    endcase
  end

  // Segment setup from the upper knot
  logic signed [32:0] dxs, nums;
  logic [31:0]        num_cl;
  assign dxs  = {rd_pos[31], rd_pos} - {lo_pos_r[31], lo_pos_r};
  assign nums = {rd_pos[31], rd_pos} - {x_r[31], x_r};
  always_comb begin
    if (nums[32]) num_cl = '0;
    else if (nums[31:0] > dxs[31:0]) num_cl = dxs[31:0];
    else num_cl = nums[31:0];
  end

  // Divider step for A
  logic        div_ge;
  logic [32:0] div_r1;
  assign div_ge = rem_r >= {1'b0, dx_r};
  assign div_r1 = div_ge ? rem_r - {1'b0, dx_r} : rem_r;

  // Divide by six in two 24-bit digits: quotient digit from the reciprocal product,
  // remainder of the upper digit carried into the lower one
  logic [23:0] dq_w, dsrc_w;
  logic [2:0]  drem_w;
  assign dq_w   = 24'(prod_r >> 30);
  assign dsrc_w = (mop_r == cse_pkg::MOP_DAH) ? qa_r[47:24] : qb_r[47:24];
  assign drem_w = 3'(dsrc_w - {dq_w[21:0], 2'b0} - {dq_w[22:0], 1'b0});

  // Shared multiplier operands
  logic [30:0] b_w;
  logic [31:0] av0, av1, ac0, ac1, mul_a, mul_b;
  assign b_w = cse_pkg::ONE_Q30 - a_r;
  assign av0 = v0_r[31] ? 32'(-v0_r) : 32'(v0_r);
  assign av1 = v1_r[31] ? 32'(-v1_r) : 32'(v1_r);
  assign ac0 = c0_r[31] ? 32'(-c0_r) : 32'(c0_r);
  assign ac1 = c1_r[31] ? 32'(-c1_r) : 32'(c1_r);

  always_comb begin
    unique case (mop_r)
      cse_pkg::MOP_A2:  begin mul_a = 32'(a_r);  mul_b = 32'(a_r); end
      cse_pkg::MOP_A3:  begin mul_a = 32'(a2_r); mul_b = 32'(a_r); end
      cse_pkg::MOP_B2:  begin mul_a = 32'(b_w);  mul_b = 32'(b_w); end
      cse_pkg::MOP_B3:  begin mul_a = 32'(b2_r); mul_b = 32'(b_w); end
      cse_pkg::MOP_MA:  begin mul_a = 32'(ta_r); mul_b = dx_r; end
      cse_pkg::MOP_MB:  begin mul_a = 32'(tb_r); mul_b = dx_r; end
      cse_pkg::MOP_MA2: begin mul_a = ma_r;      mul_b = dx_r; end
      cse_pkg::MOP_MB2: begin mul_a = mb_r;      mul_b = dx_r; end
      cse_pkg::MOP_DAH: begin mul_a = 32'(qa_r[47:24]); mul_b = cse_pkg::RECIP6_Q30; end
      cse_pkg::MOP_DAL: begin
        mul_a = 32'({ra_r, qa_r[23:0]});
        mul_b = cse_pkg::RECIP6_Q30;
      end
      cse_pkg::MOP_DBH: begin mul_a = 32'(qb_r[47:24]); mul_b = cse_pkg::RECIP6_Q30; end
      cse_pkg::MOP_DBL: begin
        mul_a = 32'({rb_r, qb_r[23:0]});
        mul_b = cse_pkg::RECIP6_Q30;
      end
      cse_pkg::MOP_VA:  begin mul_a = 32'(a_r);  mul_b = av0; end
      cse_pkg::MOP_VB:  begin mul_a = 32'(b_w);  mul_b = av1; end
      cse_pkg::MOP_CAL: begin mul_a = qa_r[31:0]; mul_b = ac0; end
      cse_pkg::MOP_CAH: begin mul_a = 32'(qa_r[47:32]); mul_b = ac0; end
      cse_pkg::MOP_CBL: begin mul_a = qb_r[31:0]; mul_b = ac1; end
      cse_pkg::MOP_CBH: begin mul_a = 32'(qb_r[47:32]); mul_b = ac1; end
      default:          begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Post-processing of the registered product
  logic signed [63:0] term30, termc;
  assign term30 = $signed({30'b0, prod_r[63:30]});
  assign termc  = $signed((prod_r << 16) + {16'b0, lo_r});

  always_comb begin
    state_nxt      = state_r;
    mop_nxt        = mop_r;
    phase_nxt      = phase_r;
    knot_count_nxt = cfg_write_en ? cfg_write_data : knot_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    x_nxt = x_r; first_nxt = first_r; count_nxt = count_r; mid_nxt = mid_r;
    j_nxt = j_r; v0_nxt = v0_r; c0_nxt = c0_r; v1_nxt = v1_r; c1_nxt = c1_r;
    lo_pos_nxt = lo_pos_r; dx_nxt = dx_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    a_nxt = a_r; a2_nxt = a2_r; b2_nxt = b2_r; ta_nxt = ta_r; tb_nxt = tb_r;
    ma_nxt = ma_r; mb_nxt = mb_r; qa_nxt = qa_r; qb_nxt = qb_r;
    ra_nxt = ra_r; rb_nxt = rb_r; lo_nxt = lo_r; acc_nxt = acc_r;
    prod_nxt = prod_r;

    unique case (state_r)
      cse_pkg::ST_IDLE: begin
        // entry 0 is being read in this cycle
        if (in_valid && (in_action == cse_pkg::ACT_EVAL)) begin
          x_nxt     = in_query_pos;
          state_nxt = cse_pkg::ST_CHK0;
        end
      end
      cse_pkg::ST_CHK0: begin
        if (x_r < rd_pos) begin
          acc_nxt   = 64'(rd_val);
          state_nxt = cse_pkg::ST_SAT;
        end else begin
          state_nxt = cse_pkg::ST_CHKN;
        end
      end
      cse_pkg::ST_CHKN: begin
        if (x_r > rd_pos) begin
          acc_nxt   = 64'(rd_val);
          state_nxt = cse_pkg::ST_SAT;
        end else begin
          first_nxt = '0;
          count_nxt = n_cl;
          state_nxt = cse_pkg::ST_SRCH;
        end
      end
      cse_pkg::ST_SRCH: begin
        if (count_r == '0) begin
          j_nxt     = j_sel;
          state_nxt = cse_pkg::ST_LO;
        end else begin
          mid_nxt   = mid_w;
          state_nxt = cse_pkg::ST_CMP;
        end
      end
      cse_pkg::ST_CMP: begin
        if (rd_pos < x_r) begin
          first_nxt = NW'(mid_r) + NW'(1);
          count_nxt = count_r - step_w - NW'(1);
        end else begin
          count_nxt = step_w;
        end
        state_nxt = cse_pkg::ST_SRCH;
      end
      cse_pkg::ST_LO: begin
        lo_pos_nxt = rd_pos;
        v0_nxt     = rd_val;
        c0_nxt     = rd_curv;
        state_nxt  = cse_pkg::ST_HI;
      end
      cse_pkg::ST_HI: begin
        v1_nxt = rd_val;
        c1_nxt = rd_curv;
        if (dxs[32] || dxs == '0) begin
          // empty or reversed segment: lower knot's value
          acc_nxt   = 64'(v0_r);
          state_nxt = cse_pkg::ST_SAT;
        end else begin
          dx_nxt    = dxs[31:0];
          rem_nxt   = {1'b0, num_cl};
          cnt_nxt   = 5'(cse_pkg::DIV_STEPS - 1);
          state_nxt = cse_pkg::ST_DIV;
        end
      end
      cse_pkg::ST_DIV: begin
        a_nxt   = {a_r[29:0], div_ge};
        rem_nxt = {div_r1[31:0], 1'b0};
        if (cnt_r == '0) begin
          mop_nxt   = cse_pkg::MOP_A2;
          phase_nxt = 1'b0;
          state_nxt = cse_pkg::ST_MUL;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      cse_pkg::ST_MUL: begin
        if (!phase_r) begin
          prod_nxt  = 64'(mul_a) * 64'(mul_b);
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          mop_nxt   = cse_pkg::mop_t'(5'(mop_r) + 5'd1);
          unique case (mop_r)
            cse_pkg::MOP_A2:  a2_nxt = 31'(prod_r >> 30);
            cse_pkg::MOP_A3:  ta_nxt = a_r - 31'(prod_r >> 30);
            cse_pkg::MOP_B2:  b2_nxt = 31'(prod_r >> 30);
            cse_pkg::MOP_B3:  tb_nxt = b_w - 31'(prod_r >> 30);
            cse_pkg::MOP_MA:  ma_nxt = 32'(prod_r >> 30);
            cse_pkg::MOP_MB:  mb_nxt = 32'(prod_r >> 30);
            cse_pkg::MOP_MA2: qa_nxt = 48'(prod_r >> 16);
            cse_pkg::MOP_MB2: qb_nxt = 48'(prod_r >> 16);
            cse_pkg::MOP_DAH: begin
              ra_nxt = drem_w;
              qa_nxt = {dq_w, qa_r[23:0]};
            end
            cse_pkg::MOP_DAL: qa_nxt = {qa_r[47:24], dq_w};
            cse_pkg::MOP_DBH: begin
              rb_nxt = drem_w;
              qb_nxt = {dq_w, qb_r[23:0]};
            end
            cse_pkg::MOP_DBL: qb_nxt = {qb_r[47:24], dq_w};
            cse_pkg::MOP_VA:  acc_nxt = v0_r[31] ? -term30 : term30;
            cse_pkg::MOP_VB:  acc_nxt = acc_r + (v1_r[31] ? -term30 : term30);
            cse_pkg::MOP_CAL: lo_nxt = prod_r[63:16];
            cse_pkg::MOP_CAH: acc_nxt = acc_r + (c0_r[31] ? termc : -termc);
            cse_pkg::MOP_CBL: lo_nxt = prod_r[63:16];
            cse_pkg::MOP_CBH: begin
              acc_nxt   = acc_r + (c1_r[31] ? termc : -termc);
              state_nxt = cse_pkg::ST_SAT;
            end
            default: state_nxt = cse_pkg::ST_SAT;
          endcase
        end
      end
      cse_pkg::ST_SAT: begin
        if (!out_valid_r || !out_stall) begin
          priority if (acc_r > cse_pkg::SAT_MAX) out_value_nxt = 32'(cse_pkg::SAT_MAX);
          else if (acc_r < cse_pkg::SAT_MIN) out_value_nxt = 32'(cse_pkg::SAT_MIN);
          else out_value_nxt = 32'(acc_r);
          out_valid_nxt = 1'b1;
          state_nxt     = cse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cse_pkg::ST_IDLE;
      mop_r        <= cse_pkg::MOP_A2;
      phase_r      <= 1'b0;
      knot_count_r <= 7'd2;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mop_r        <= mop_nxt;
      phase_r      <= phase_nxt;
      knot_count_r <= knot_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    x_r <= x_nxt; first_r <= first_nxt; count_r <= count_nxt; mid_r <= mid_nxt;
    j_r <= j_nxt; v0_r <= v0_nxt; c0_r <= c0_nxt; v1_r <= v1_nxt; c1_r <= c1_nxt;
    lo_pos_r <= lo_pos_nxt; dx_r <= dx_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    a_r <= a_nxt; a2_r <= a2_nxt; b2_r <= b2_nxt; ta_r <= ta_nxt; tb_r <= tb_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; qa_r <= qa_nxt; qb_r <= qb_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt; lo_r <= lo_nxt; acc_r <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign in_stall         = (state_r != cse_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_spline_value = out_value_r;

endmodule

// ===== hdl/cse_checker.sv =====
// Port-level assertions for the cubic spline evaluator, bound to the top level.
`include "cubic_spline_evaluator_unit_defines.svh"

module cse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_action,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_spline_value
);

  // a stalled result holds
  `CSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_spline_value), "stalled result changed")
  // an evaluate request occupies the block
  `CSE_ASSERT_NEXT(a_eval_busy, clk, rst_n,
                   in_valid && !in_stall && (in_action == cse_pkg::ACT_EVAL),
                   in_stall, "evaluate did not occupy block")
  // a load request does not occupy the block
  `CSE_ASSERT_NEXT(a_load_free, clk, rst_n,
                   in_valid && !in_stall && (in_action == cse_pkg::ACT_LOAD),
                   !in_stall, "load held the block")
  // the block frees up only when it delivers a result
  `CSE_ASSERT_SAME(a_done_out, clk, rst_n, $fell(in_stall), out_valid,
                   "block freed without a result")

endmodule

bind cubic_spline_evaluator_unit cse_checker u_cse_checker (.*);
